/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/shamd_pkg.sv */
package shamd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        final_word;
	} out_t;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic [7:0] PadByte  = 8'h80;
	localparam logic [5:0] LenStart = 6'd56;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

/* sv/shamd_front.sv */
module shamd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  shamd_pkg::in_t  byte_req,
	output logic            q_valid,
	input  logic            q_pop,
	output shamd_pkg::in_t  q_head
);

	shamd_pkg::in_t           fifo_q [shamd_pkg::QDepth];
	logic [shamd_pkg::QAw-1:0] wr_q, rd_q;
	logic [shamd_pkg::QAw:0]   cnt_q;
	logic push, pop;

	// items carrying neither byte nor end are dropped here
	assign byte_stall = (cnt_q == (shamd_pkg::QAw+1)'(shamd_pkg::QDepth));
	assign push = byte_valid && !byte_stall && (byte_req.byte_present || byte_req.message_end);
	assign q_valid = (cnt_q != '0);
	assign pop = q_pop && q_valid;
	assign q_head = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= byte_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/shamd_back.sv */
module shamd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_pop,
	input  shamd_pkg::in_t  q_head,
	output logic            digest_valid,
	input  logic            digest_stall,
	output shamd_pkg::out_t digest_req
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	logic [2:0]  st_q, ret_q;
	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  fill_q, rnd_q;
	logic [63:0] bits_q, len_q;
	logic        p80_q;
	logic [2:0]  lcnt_q, idx_q;

	logic        put;
	logic [7:0]  put_byte;
	logic        len_sel;
	logic [31:0] t1, t2, wnew, s0, s1, e, a;
	logic [2:0]  lsh;

	assign q_pop = (st_q == ST_LOAD);
	assign len_sel = p80_q && (lcnt_q != '0 || fill_q == shamd_pkg::LenStart);
	assign lsh = ~lcnt_q;

	always_comb begin
		put = 1'b0;
		put_byte = q_head.data_byte;
		if (st_q == ST_LOAD) begin
			put = q_valid && q_head.byte_present;
		end else if (st_q == ST_PAD) begin
			put = 1'b1;
			if (!p80_q) begin
				put_byte = shamd_pkg::PadByte;
			end else if (len_sel) begin
				put_byte = len_q[{lsh, 3'b000} +: 8];
			end else begin
				put_byte = 8'h00;
			end
		end
	end

	assign e = v_q[4];
	assign a = v_q[0];
	assign t1 = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + shamd_pkg::RoundK[rnd_q] + w_q[0];
	assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnew = s1 + w_q[9] + s0 + w_q[0];

	assign digest_valid = (st_q == ST_OUT);
	assign digest_req.digest_word = chain_q[idx_q];
	assign digest_req.word_index  = idx_q;
	assign digest_req.final_word  = (idx_q == 3'd7);

	// block words and working variables
	always_ff @(posedge clk) begin
		if (put) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= put_byte;
		end else if (st_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= wnew;
		end
		if (st_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			v_q <= chain_q;
		end
		if (st_q == ST_LOAD && q_valid && q_head.message_end) begin
			len_q <= bits_q + (q_head.byte_present ? 64'd8 : 64'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_LOAD;
			ret_q   <= ST_LOAD;
			chain_q <= shamd_pkg::InitHash;
			fill_q  <= '0;
			rnd_q   <= '0;
			bits_q  <= '0;
			p80_q   <= 1'b0;
			lcnt_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (put) begin
				fill_q <= fill_q + 1'b1;
			end
			case (st_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (q_head.byte_present) begin
							bits_q <= bits_q + 64'd8;
						end
						if (q_head.byte_present && fill_q == 6'd63) begin
							st_q  <= ST_ROUND;
							ret_q <= q_head.message_end ? ST_PAD : ST_LOAD;
						end else if (q_head.message_end) begin
							st_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					p80_q <= 1'b1;
					if (len_sel) begin
						lcnt_q <= lcnt_q + 1'b1;
					end
					if (fill_q == 6'd63) begin
						st_q  <= ST_ROUND;
						ret_q <= (len_sel && lcnt_q == 3'd7) ? ST_OUT : ST_PAD;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						st_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
					idx_q <= '0;
					st_q  <= ret_q;
				end
				ST_OUT: begin
					if (!digest_stall) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7) begin
							chain_q <= shamd_pkg::InitHash;
							fill_q  <= '0;
							bits_q  <= '0;
							p80_q   <= 1'b0;
							lcnt_q  <= '0;
							st_q    <= ST_LOAD;
						end
					end
				end
				default: begin
					st_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

/* sv/sha256_message_digest.sv */
// SHA-256 digest of a byte stream.
// Input channel byte_valid/byte_stall/byte_req: one request per message byte
// (byte_present) and/or end of message (message_end). A request with neither
// is taken and ignored. Requests go into a four-deep queue, so the sender is
// stalled only when that queue is full.
// Output channel digest_valid/digest_stall/digest_req: after an end request,
// eight 32-bit digest words, index 0 (most significant) first, final_word on
// index 7. The words stay valid and unchanged while digest_stall is high.
// Throughput: one byte per cycle while a block loads; each 64-byte block is
// then compressed by the 64 rounds of the single round unit and the chain add,
// while no requests leave the queue.
// After the end request is taken (and the block that its byte completes, if any,
// is compressed), padding writes a byte a cycle, over two pad blocks when the
// length does not fit; each pad block is compressed, then one digest word per
// cycle goes out if not stalled.
// Reset clears the queue and returns the hash state to the initial values;
// the block takes requests from the first cycle after reset.
module sha256_message_digest (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  shamd_pkg::in_t  byte_req,
	output logic            digest_valid,
	input  logic            digest_stall,
	output shamd_pkg::out_t digest_req
);

	logic           q_valid, q_pop;
	shamd_pkg::in_t q_head;

	shamd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_req   (byte_req),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_head     (q_head)
	);

	shamd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_head       (q_head),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_req   (digest_req)
	);

endmodule

/* sv/shamd_checker.sv */
`include "assert_macros.svh"

module shamd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            digest_valid,
	input logic            digest_stall,
	input shamd_pkg::out_t digest_req
);

	`CHK_NEXT(a_hold, digest_valid && digest_stall, digest_valid && $stable(digest_req))
	`CHK_NOW(a_final, digest_valid, digest_req.final_word == (digest_req.word_index == 3'd7))
	`CHK_NEXT(a_seq, digest_valid && !digest_stall && !digest_req.final_word,
		digest_valid && digest_req.word_index == $past(digest_req.word_index) + 3'd1)
	`CHK_NEXT(a_gap, digest_valid && !digest_stall && digest_req.final_word, !digest_valid)

endmodule

bind sha256_message_digest shamd_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.digest_valid (digest_valid),
	.digest_stall (digest_stall),
	.digest_req   (digest_req)
);
